// ----- rtl/dxt_block_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the DXT block decoder
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_ASSERT_SVH
`define DXT_BLOCK_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DXTBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define DXTBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dxtbd_pkg.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder package
// Format codes, palette types and the fixed-point helpers for the palettes.
// ----------------------------------------------------------------------------
package dxtbd_pkg;

  localparam logic [2:0] FMT_DXT1     = 3'd1;
  localparam logic [2:0] FMT_EXPL_A   = 3'd2;
  localparam logic [2:0] FMT_EXPL_B   = 3'd3;
  localparam logic [2:0] FMT_INTERP_A = 3'd4;
  localparam logic [2:0] FMT_INTERP_B = 3'd5;

  localparam logic [3:0] LAST_TEXEL = 4'd15;

  // reciprocal multipliers: exact floors over the operand ranges used here
  localparam int unsigned DIV3_MUL = 683;   // x < 768,  shift 11
  localparam int unsigned DIV5_MUL = 3277;  // x < 1280, shift 14
  localparam int unsigned DIV7_MUL = 2341;  // x < 1792, shift 14

  // colour palette: RGB per entry, alpha is opaque except entry 3 in
  // three-colour mode
  typedef struct packed {
    logic [3:0][23:0] rgb;
    logic             trans3;
  } cpal_t;

  typedef logic [7:0][7:0] apal_t;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'(DIV3_MUL);
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'(DIV5_MUL);
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'(DIV7_MUL);
    return p[21:14];
  endfunction

  // (2a + b + 1) / 3
  function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
    return div3({1'b0, a, 1'b0} + {2'b00, b} + 10'd1);
  endfunction

  // (a + b + 1) / 2
  function automatic logic [7:0] mix_half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // ((7-k)*a0 + k*a1 + 3) / 7
  function automatic logic [7:0] alpha_mix7(input logic [2:0] k, input logic [7:0] a0,
                                            input logic [7:0] a1);
    logic [10:0] x;
    x = {8'd0, 3'd7 - k} * {3'd0, a0} + {8'd0, k} * {3'd0, a1} + 11'd3;
    return div7(x);
  endfunction

  // ((5-k)*a0 + k*a1 + 2) / 5
  function automatic logic [7:0] alpha_mix5(input logic [2:0] k, input logic [7:0] a0,
                                            input logic [7:0] a1);
    logic [10:0] x;
    x = {8'd0, 3'd5 - k} * {3'd0, a0} + {8'd0, k} * {3'd0, a1} + 11'd2;
    return div5(x);
  endfunction

endpackage

// ----- rtl/dxtbd_palette.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder palette builder
// Builds the four-entry colour palette and the eight-entry alpha palette.
// ----------------------------------------------------------------------------
module dxtbd_palette (
  input  logic [31:0]          endpoints,
  input  logic [15:0]          alpha_ends,
  input  logic [2:0]           fmt,
  output dxtbd_pkg::cpal_t     cpal,
  output dxtbd_pkg::apal_t     apal
);

  logic [15:0] c0;
  logic [15:0] c1;
  logic [23:0] e0;
  logic [23:0] e1;
  logic        three_colour;
  logic [7:0]  a0;
  logic [7:0]  a1;

  assign c0 = endpoints[15:0];
  assign c1 = endpoints[31:16];
  assign e0 = dxtbd_pkg::expand565(c0);
  assign e1 = dxtbd_pkg::expand565(c1);
  assign three_colour = (fmt == dxtbd_pkg::FMT_DXT1) && (c0 <= c1);
  assign a0 = alpha_ends[7:0];
  assign a1 = alpha_ends[15:8];

  always_comb begin
    cpal.rgb[0] = e0;
    cpal.rgb[1] = e1;
    cpal.trans3 = three_colour;
    for (int ch = 0; ch < 3; ch++) begin
      if (three_colour) begin
        cpal.rgb[2][8*ch +: 8] = dxtbd_pkg::mix_half(e0[8*ch +: 8], e1[8*ch +: 8]);
        cpal.rgb[3][8*ch +: 8] = 8'd0;
      end else begin
        cpal.rgb[2][8*ch +: 8] = dxtbd_pkg::mix_third(e0[8*ch +: 8], e1[8*ch +: 8]);
        cpal.rgb[3][8*ch +: 8] = dxtbd_pkg::mix_third(e1[8*ch +: 8], e0[8*ch +: 8]);
      end
    end
  end

  always_comb begin
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      apal[2] = dxtbd_pkg::alpha_mix7(3'd1, a0, a1);
      apal[3] = dxtbd_pkg::alpha_mix7(3'd2, a0, a1);
      apal[4] = dxtbd_pkg::alpha_mix7(3'd3, a0, a1);
      apal[5] = dxtbd_pkg::alpha_mix7(3'd4, a0, a1);
      apal[6] = dxtbd_pkg::alpha_mix7(3'd5, a0, a1);
      apal[7] = dxtbd_pkg::alpha_mix7(3'd6, a0, a1);
    end else begin
      apal[2] = dxtbd_pkg::alpha_mix5(3'd1, a0, a1);
      apal[3] = dxtbd_pkg::alpha_mix5(3'd2, a0, a1);
      apal[4] = dxtbd_pkg::alpha_mix5(3'd3, a0, a1);
      apal[5] = dxtbd_pkg::alpha_mix5(3'd4, a0, a1);
      apal[6] = 8'h00;
      apal[7] = 8'hFF;
    end
  end

endmodule

// ----- rtl/dxtbd_texel_select.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder texel selector
// Picks one texel from the palettes and merges in its alpha for the format.
// ----------------------------------------------------------------------------
module dxtbd_texel_select (
  input  logic [3:0]           pos,
  input  logic [2:0]           fmt,
  input  dxtbd_pkg::cpal_t     cpal,
  input  dxtbd_pkg::apal_t     apal,
  input  logic [31:0]          indices,
  input  logic [63:0]          alpha_half,
  output logic [31:0]          argb
);

  logic [4:0]  cbase;
  logic [5:0]  nbase;
  logic [5:0]  abase;
  logic [1:0]  code;
  logic [3:0]  nibble;
  logic [2:0]  acode;
  logic [47:0] acodes;
  logic [7:0]  alpha;

  assign cbase  = {pos, 1'b0};
  assign nbase  = {pos, 2'b00};
  assign abase  = {1'b0, pos, 1'b0} + {2'b00, pos};
  assign acodes = alpha_half[63:16];
  assign code   = indices[cbase +: 2];
  assign nibble = alpha_half[nbase +: 4];
  assign acode  = acodes[abase +: 3];

  always_comb begin
    case (fmt)
      dxtbd_pkg::FMT_DXT1: begin
        alpha = (cpal.trans3 && (code == 2'd3)) ? 8'h00 : 8'hFF;
      end
      dxtbd_pkg::FMT_EXPL_A,
      dxtbd_pkg::FMT_EXPL_B: begin
        alpha = {nibble, nibble};
      end
      dxtbd_pkg::FMT_INTERP_A,
      dxtbd_pkg::FMT_INTERP_B: begin
        alpha = apal[acode];
      end
      default: begin
        alpha = 8'h00;
      end
    endcase
  end

  assign argb = {alpha, cpal.rgb[code]};

endmodule

// ----- rtl/dxt_block_decoder.sv -----
// ----------------------------------------------------------------------------
// DXT block decoder
// Decodes one DXT1/DXT3/DXT5 4x4 block into sixteen ARGB8888 texels.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. Sixteen texels follow,
// one per cycle in row-major order, each marked by a one-cycle strobe with
// last_texel on the sixteenth; the receiver must take every texel as it comes.
// The first texel reaches the ports through the input, palette and result registers.
// A block is held in an input register while the previous one is emitted, so
// blocks stream back to back, paced by the single texel output.
// block_format may only be written while no block is in flight.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_assert.svh"

module dxt_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] alpha_block,
  input  logic [63:0] color_block,
  output logic        strobe,
  output logic [31:0] texel_argb,
  output logic [3:0]  texel_index,
  output logic        last_texel
);

  logic [2:0]        block_format;

  logic              in_full;
  logic              in_full_next;
  logic [63:0]       in_alpha;
  logic [63:0]       in_color;

  logic              pal_full;
  logic              pal_full_next;
  logic [3:0]        cnt;
  logic [2:0]        pal_fmt;
  dxtbd_pkg::cpal_t  pal_cpal;
  dxtbd_pkg::apal_t  pal_apal;
  logic [31:0]       pal_idx;
  logic [63:0]       pal_alpha;

  dxtbd_pkg::cpal_t  cpal_calc;
  dxtbd_pkg::apal_t  apal_calc;
  logic [31:0]       argb_sel;

  logic              accept;
  logic              emit_end;
  logic              xfer;

  assign emit_end = pal_full && (cnt == dxtbd_pkg::LAST_TEXEL);
  assign xfer     = in_full && (!pal_full || emit_end);
  assign busy     = in_full && !xfer;
  assign accept   = start && !busy;

  assign in_full_next  = accept ? 1'b1 : (xfer ? 1'b0 : in_full);
  assign pal_full_next = xfer ? 1'b1 : (emit_end ? 1'b0 : pal_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= dxtbd_pkg::FMT_DXT1;
    end else if (cfg_write) begin
      block_format <= cfg_data;
    end
  end

  // input register: holds the next block while the current one is emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_alpha <= alpha_block;
      in_color <= color_block;
    end
  end

  dxtbd_palette u_palette (
    .endpoints  (in_color[31:0]),
    .alpha_ends (in_alpha[15:0]),
    .fmt        (block_format),
    .cpal       (cpal_calc),
    .apal       (apal_calc)
  );

  // palette register and texel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_full <= 1'b0;
      cnt      <= 4'd0;
    end else begin
      pal_full <= pal_full_next;
      if (xfer) begin
        cnt <= 4'd0;
      end else if (pal_full) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      pal_fmt   <= block_format;
      pal_cpal  <= cpal_calc;
      pal_apal  <= apal_calc;
      pal_idx   <= in_color[63:32];
      pal_alpha <= in_alpha;
    end
  end

  dxtbd_texel_select u_select (
    .pos        (cnt),
    .fmt        (pal_fmt),
    .cpal       (pal_cpal),
    .apal       (pal_apal),
    .indices    (pal_idx),
    .alpha_half (pal_alpha),
    .argb       (argb_sel)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      last_texel <= 1'b0;
    end else begin
      strobe     <= pal_full;
      last_texel <= emit_end;
    end
  end

  always_ff @(posedge clk) begin
    texel_argb  <= argb_sel;
    texel_index <= cnt;
  end

  `DXTBD_ASSERT_SAME(a_last_at_end, clk, rst, last_texel,
    strobe && (texel_index == dxtbd_pkg::LAST_TEXEL), "last_texel off the final texel")
  `DXTBD_ASSERT_NEXT(a_texels_run, clk, rst, strobe && !last_texel,
    strobe && (texel_index == $past(texel_index) + 4'd1), "texel run broken")
  `DXTBD_ASSERT_NEXT(a_accept_held, clk, rst, accept, in_full, "accepted block not held")
  `DXTBD_ASSERT_NEXT(a_no_spurious, clk, rst, !pal_full, !strobe, "texel without block")

endmodule
